[rtl/mpsa_pkg.sv]
// ----------------------------------------------------------------------------
// mpsa_pkg
// shared types and constants of the multi-pool slot allocator
// ----------------------------------------------------------------------------
package mpsa_pkg;

  localparam int NUM_TYPES_DEF = 4;
  localparam int CAPACITY_DEF  = 1024;

  localparam int KIND_W   = 2;
  localparam int POOL_W   = 2;
  localparam int SLOT_W   = 10;
  localparam int OFF_W    = 22;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 13;

  localparam int NUM_REGS  = 4;
  localparam int REG_IDX_W = 2;
  localparam int CFG_IDX_W = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POOL_W-1:0] pool_type;
    logic [SLOT_W-1:0] slot_in;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic [OFF_W-1:0]    byte_offset;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

[rtl/multi_pool_slot_allocator.sv]
// ----------------------------------------------------------------------------
// multi_pool_slot_allocator
// slot allocator over several pools with bump counters and lifo free stacks
// ----------------------------------------------------------------------------
// One item (allocate, free or clear) is taken every clock cycle; busy is high
// only while reset is applied. Each item yields exactly one result on out_data,
// marked by out_valid for one cycle. The first register stage holds the
// free-stack memory read and the item's fields, the second the registered
// multiply of element size by slot. Counters live in flip-flops and are
// updated as the item is taken, so back-to-back items see each other's
// effects; the free stacks need no clearing pass after reset or clear.
// ----------------------------------------------------------------------------
module multi_pool_slot_allocator
  import mpsa_pkg::*;
#(
  parameter int NUM_TYPES = NUM_TYPES_DEF,
  parameter int CAPACITY  = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata
);

  localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DEPTH  = NUM_TYPES * CAPACITY;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]  bump_r [NUM_TYPES];
  logic [CNT_W-1:0]  bump_nxt [NUM_TYPES];
  logic [CNT_W-1:0]  free_r [NUM_TYPES];
  logic [CNT_W-1:0]  free_nxt [NUM_TYPES];
  logic [SIZE_W-1:0] elem_size_r [NUM_REGS];

  logic [SLOT_W-1:0] stack_mem [DEPTH];
  logic [SLOT_W-1:0] rd_data_r;

  logic                accept;
  logic                pool_ok;
  logic [TYPE_W+1:0]   pool_w;
  logic [TYPE_W-1:0]   pool_idx;
  logic [CNT_W-1:0]    cur_free;
  logic [CNT_W-1:0]    cur_bump;
  logic [CNT_W-1:0]    cur_free_m1;
  logic [CNT_W+SLOT_W-1:0] bump_ext;
  logic [ADDR_W-1:0]   base_addr;
  logic [ADDR_W-1:0]   mem_addr;
  logic                mem_we;
  logic                mem_re;

  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_pop_r, s1_pop_nxt;
  logic [SLOT_W-1:0]   s1_slot_r, s1_slot_nxt;
  logic [SIZE_W-1:0]   s1_size_r, s1_size_nxt;
  logic [STATUS_W-1:0] s1_status_r, s1_status_nxt;

  logic                    out_valid_r;
  out_item_t               out_r, out_nxt;
  logic [SLOT_W-1:0]       grant_slot;
  logic [SIZE_W+SLOT_W-1:0] product;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  assign pool_ok     = 32'(in_data.pool_type) < NUM_TYPES;
  assign pool_w      = (TYPE_W + 2)'(in_data.pool_type);
  assign pool_idx    = pool_w[TYPE_W-1:0];
  assign cur_free    = free_r[pool_idx];
  assign cur_bump    = bump_r[pool_idx];
  assign cur_free_m1 = cur_free - CNT_W'(1);
  assign bump_ext    = (CNT_W + SLOT_W)'(cur_bump);
  assign base_addr   = ADDR_W'(int'(pool_idx) * CAPACITY);

  always_comb begin
    bump_nxt      = bump_r;
    free_nxt      = free_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = base_addr + ADDR_W'(cur_free);
    s1_valid_nxt  = accept;
    s1_pop_nxt    = 1'b0;
    s1_slot_nxt   = '0;
    s1_size_nxt   = '0;
    s1_status_nxt = ST_OK;
    if (accept) begin
      unique case (in_data.kind)
        KIND_ALLOC: begin
          if (!pool_ok) begin
            s1_status_nxt = ST_EXHAUSTED;
          end else if (cur_free != '0) begin
            free_nxt[pool_idx] = cur_free_m1;
            mem_re             = 1'b1;
            mem_addr           = base_addr + ADDR_W'(cur_free_m1);
            s1_pop_nxt         = 1'b1;
            s1_size_nxt        = elem_size_r[in_data.pool_type];
          end else if (cur_bump != CAP_CNT) begin
            bump_nxt[pool_idx] = cur_bump + CNT_W'(1);
            s1_slot_nxt        = bump_ext[SLOT_W-1:0];
            s1_size_nxt        = elem_size_r[in_data.pool_type];
          end else begin
            s1_status_nxt = ST_EXHAUSTED;
          end
        end
        KIND_FREE: begin
          if (!pool_ok || cur_free == CAP_CNT) begin
            s1_status_nxt = ST_STACK_FULL;
          end else begin
            free_nxt[pool_idx] = cur_free + CNT_W'(1);
            mem_we             = 1'b1;
          end
        end
        KIND_CLEAR: begin
          for (int t = 0; t < NUM_TYPES; t++) begin
            bump_nxt[t] = '0;
            free_nxt[t] = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // free-stack memory, one synchronous port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_addr] <= in_data.slot_in;
    end
    if (mem_re) begin
      rd_data_r <= stack_mem[mem_addr];
    end
  end

  assign grant_slot = s1_pop_r ? rd_data_r : s1_slot_r;
  assign product    = s1_size_r * grant_slot;

  always_comb begin
    out_nxt.slot_out    = grant_slot;
    out_nxt.byte_offset = product[OFF_W-1:0];
    out_nxt.status      = s1_status_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TYPES; t++) begin
        bump_r[t] <= '0;
        free_r[t] <= '0;
      end
      for (int r = 0; r < NUM_REGS; r++) begin
        elem_size_r[r] <= SIZE_RESET;
      end
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      bump_r      <= bump_nxt;
      free_r      <= free_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= s1_valid_r;
      if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
        elem_size_r[cfg_index[REG_IDX_W-1:0]] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_pop_r    <= s1_pop_nxt;
    s1_slot_r   <= s1_slot_nxt;
    s1_size_r   <= s1_size_nxt;
    s1_status_r <= s1_status_nxt;
    out_r       <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##2 out_valid)
    else $error("item taken without a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 2))
    else $error("result without a taken item");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.slot_out == '0 && out_data.byte_offset == '0))
    else $error("failed request returned a slot");
`endif

endmodule

[tb/mpsa_checker.sv]
// ----------------------------------------------------------------------------
// mpsa_checker
// watches the item, result and register ports of the multi-pool slot
// allocator. It keeps its own copy of the bump counters, free stacks and
// element sizes, works out the result owed for every accepted item and
// compares each result, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module mpsa_checker
  import mpsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  logic [SIZE_W-1:0] elem_bytes  [NUM_REGS];
  logic [SLOT_W:0]   bump_cnt    [NUM_TYPES_DEF];
  logic [SLOT_W:0]   stack_depth [NUM_TYPES_DEF];
  logic [SLOT_W-1:0] stack_mem   [NUM_TYPES_DEF][CAPACITY_DEF];
  out_item_t         owed_results [$];

  function automatic out_item_t serve_request(in_item_t req);
    out_item_t                res;
    logic [POOL_W-1:0]        p;
    logic [SLOT_W-1:0]        slot;
    logic [SIZE_W+SLOT_W-1:0] product;
    res = '0;
    p = req.pool_type;
    case (req.kind)
      KIND_ALLOC: begin
        if (stack_depth[p] != '0) begin
          stack_depth[p] = stack_depth[p] - (SLOT_W + 1)'(1);
          slot = stack_mem[p][stack_depth[p][SLOT_W-1:0]];
        end else if (bump_cnt[p] < (SLOT_W + 1)'(CAPACITY_DEF)) begin
          slot = bump_cnt[p][SLOT_W-1:0];
          bump_cnt[p] = bump_cnt[p] + (SLOT_W + 1)'(1);
        end else begin
          res.status = ST_EXHAUSTED;
          return res;
        end
        product = elem_bytes[p] * slot;
        res.slot_out = slot;
        res.byte_offset = product[OFF_W-1:0];
        res.status = ST_OK;
      end
      KIND_FREE: begin
        if (stack_depth[p] >= (SLOT_W + 1)'(CAPACITY_DEF)) begin
          res.status = ST_STACK_FULL;
        end else begin
          stack_mem[p][stack_depth[p][SLOT_W-1:0]] = req.slot_in;
          stack_depth[p] = stack_depth[p] + (SLOT_W + 1)'(1);
        end
      end
      KIND_CLEAR: begin
        for (int t = 0; t < NUM_TYPES_DEF; t++) begin
          bump_cnt[t] = '0;
          stack_depth[t] = '0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int t = 0; t < NUM_TYPES_DEF; t++) begin
        bump_cnt[t] = '0;
        stack_depth[t] = '0;
      end
      for (int r = 0; r < NUM_REGS; r++) begin
        elem_bytes[r] = SIZE_RESET;
      end
      owed_results.delete();
    end else begin
      if (out_valid) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with no item outstanding, expected none got %p",
                   $time, out_data);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (out_data.slot_out !== want.slot_out)
            report_field("slot_out", 32'(want.slot_out), 32'(out_data.slot_out));
          if (out_data.byte_offset !== want.byte_offset)
            report_field("byte_offset", 32'(want.byte_offset),
                         32'(out_data.byte_offset));
          if (out_data.status !== want.status)
            report_field("status", 32'(want.status), 32'(out_data.status));
        end
      end
      if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
        elem_bytes[cfg_index[REG_IDX_W-1:0]] = cfg_wdata;
      end
      if (start && !busy) begin
        owed_results.push_back(serve_request(in_data));
      end
    end
    outstanding = owed_results.size();
  end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// stimulus for the multi-pool slot allocator: a short directed run over
// allocate, free, clear and the unused kind at reset and extreme element
// sizes, then random items over several size settings, including a pass
// that overflows one pool's free stack and pops 60 slots back. Results are checked
// by mpsa_checker.
// ----------------------------------------------------------------------------
module tb;
  import mpsa_pkg::*;

  localparam int RUN_LIMIT   = 200000;
  localparam int PHASE_ITEMS = 30;
  localparam int NUM_PHASES  = 4;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_wdata;
  int                   mismatches;
  int                   outstanding;
  bit                   gaps_on;

  multi_pool_slot_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mpsa_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t make_item(logic [KIND_W-1:0] k, logic [POOL_W-1:0] p,
                                         logic [SLOT_W-1:0] s);
    in_item_t it;
    it.kind = k;
    it.pool_type = p;
    it.slot_in = s;
    return it;
  endfunction

  function automatic logic [SLOT_W-1:0] pick_slot();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 15) return '1;
    return SLOT_W'($urandom_range(0, 2**SLOT_W - 1));
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 9) == 0) return SIZE_W'($urandom_range(0, 2**SIZE_W - 1));
    return SIZE_W'($urandom_range(1, 4096));
  endfunction

  function automatic in_item_t random_item();
    int                r;
    logic [KIND_W-1:0] k;
    r = $urandom_range(0, 99);
    if (r < 48) k = KIND_ALLOC;
    else if (r < 95) k = KIND_FREE;
    else if (r < 97) k = KIND_CLEAR;
    else k = KIND_UNUSED;
    return make_item(k, POOL_W'($urandom_range(0, 3)), pick_slot());
  endfunction

  // traffic on the other pools that leaves pool p alone
  function automatic in_item_t side_item(logic [POOL_W-1:0] p);
    int                r;
    logic [KIND_W-1:0] k;
    r = $urandom_range(0, 2);
    k = (r == 0) ? KIND_ALLOC : (r == 1) ? KIND_FREE : KIND_UNUSED;
    return make_item(k, p + POOL_W'($urandom_range(1, 3)), pick_slot());
  endfunction

  task automatic idle_gap();
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 26) begin
        start <= 1'b0;
        in_data <= in_item_t'($urandom);
        @(negedge clk);
      end
    end
  endtask

  task automatic send_item(in_item_t it);
    idle_gap();
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic program_sizes(logic [SIZE_W-1:0] s0, logic [SIZE_W-1:0] s1,
                               logic [SIZE_W-1:0] s2, logic [SIZE_W-1:0] s3, bit stray);
    logic [SIZE_W-1:0] sizes [NUM_REGS];
    sizes = '{s0, s1, s2, s3};
    for (int r = 0; r < NUM_REGS; r++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_wdata <= sizes[r];
      @(negedge clk);
    end
    // unmapped index must leave the sizes alone
    if (stray) begin
      cfg_index <= CFG_IDX_W'($urandom_range(NUM_REGS, 2**CFG_IDX_W - 1));
      cfg_wdata <= SIZE_W'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic hammer_pool(logic [KIND_W-1:0] k, logic [POOL_W-1:0] p, int count);
    int n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(side_item(p));
      end else begin
        send_item(make_item(k, p, pick_slot()));
        n++;
      end
    end
  endtask

  initial begin
    logic [POOL_W-1:0] deep_pool;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    gaps_on = 1'b1;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset sizes: bump, lifo pop, unused kind, clear
    send_item(make_item(KIND_ALLOC, 2'd0, '0));
    send_item(make_item(KIND_ALLOC, 2'd0, '0));
    send_item(make_item(KIND_ALLOC, 2'd1, '1));
    send_item(make_item(KIND_ALLOC, 2'd2, '0));
    send_item(make_item(KIND_ALLOC, 2'd3, '1));
    send_item(make_item(KIND_FREE, 2'd0, '1));
    send_item(make_item(KIND_FREE, 2'd0, '0));
    send_item(make_item(KIND_ALLOC, 2'd0, '1));
    send_item(make_item(KIND_ALLOC, 2'd0, '0));
    send_item(make_item(KIND_ALLOC, 2'd0, '0));
    send_item(make_item(KIND_UNUSED, 2'd3, '1));
    send_item(make_item(KIND_CLEAR, 2'd1, '1));
    send_item(make_item(KIND_ALLOC, 2'd0, '1));

    // extreme sizes, top slot: largest offset, wrapped offset, zero size
    settle();
    program_sizes(SIZE_W'(4096), SIZE_W'(1), '0, '1, 1'b1);
    for (int p = 0; p < NUM_TYPES_DEF; p++) begin
      send_item(make_item(KIND_FREE, POOL_W'(p), '1));
      send_item(make_item(KIND_ALLOC, POOL_W'(p), '0));
    end
    send_item(make_item(KIND_CLEAR, 2'd0, '0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      program_sizes(pick_size(), pick_size(), pick_size(), pick_size(),
                    bit'($urandom_range(0, 1)));
      gaps_on = (ph != 1);
      if (ph == 2) begin
        // overflow one pool's free stack, then pop 60 slots back
        deep_pool = POOL_W'($urandom_range(0, 3));
        send_item(make_item(KIND_CLEAR, deep_pool, '0));
        hammer_pool(KIND_FREE, deep_pool, CAPACITY_DEF + 4);
        hammer_pool(KIND_ALLOC, deep_pool, 60);
      end
      repeat ((ph == 1) ? 3 * PHASE_ITEMS : PHASE_ITEMS) send_item(random_item());
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("** multi_pool_slot_allocator: PASSED **");
    end else begin
      $display("** multi_pool_slot_allocator: FAILED **");
    end
    $finish;
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("timeout with %0d results outstanding", outstanding);
    $display("** multi_pool_slot_allocator: FAILED **");
    $finish;
  end

endmodule

[multi_pool_slot_allocator.f]
rtl/mpsa_pkg.sv
rtl/multi_pool_slot_allocator.sv
tb/mpsa_checker.sv
tb/tb.sv
